// ===== hdl/pfqg_pkg.sv =====
`default_nettype none
package pfqg_pkg;
  localparam int MaxParticles = 16;
  localparam int LifeW = 24;
  localparam int PosW = 20;

  localparam logic [1:0] ReqAdd  = 2'd0;
  localparam logic [1:0] ReqTick = 2'd1;
  localparam logic [1:0] ReqDraw = 2'd2;

  localparam logic [1:0] StVertex  = 2'd0;
  localparam logic [1:0] StAddOk   = 2'd1;
  localparam logic [1:0] StAddDrop = 2'd2;

  localparam logic [2:0] CfgColor  = 3'd0;
  localparam logic [2:0] CfgBase   = 3'd1;
  localparam logic [2:0] CfgLeft   = 3'd2;
  localparam logic [2:0] CfgTop    = 3'd3;
  localparam logic [2:0] CfgWidth  = 3'd4;
  localparam logic [2:0] CfgHeight = 3'd5;

  // Divider handshake between the sequencer and the alpha unit.
  typedef struct packed {
    logic             start;
    logic [LifeW-1:0] life;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] alpha;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/pfqg_alpha_div.sv =====
`default_nettype none
// Restoring divider: computes min(255, floor(255*life/base)), one quotient bit a cycle.
module pfqg_alpha_div import pfqg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [LifeW-1:0] base,
  input  wire div_req_t         req,
  output div_rsp_t              rsp
);
  localparam int NumW = LifeW + 8;

  logic [NumW-1:0]  num;
  logic [LifeW:0]   rem;
  logic [NumW-1:0]  quo;
  logic [5:0]       cnt;
  logic             busy;
  logic [LifeW:0]   rem_sh;
  logic [LifeW+1:0] diff;

  assign rem_sh = {rem[LifeW-1:0], num[NumW-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, base};

  // Iterate over the numerator bits; handle a zero base on the side.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
      cnt <= '0;
    end else begin
      // Done pulses right away for a zero base, otherwise on the last step.
      rsp.done <= (req.start && base == '0) || (busy && cnt == 6'd1);
      if (req.start) begin
        if (base == '0) begin
          rsp.alpha <= (req.life != '0) ? 8'd255 : 8'd0;
        end else begin
          busy <= 1'b1;
          num <= ({8'd0, req.life} << 8) - {8'd0, req.life};
          rem <= '0;
          quo <= '0;
          cnt <= 6'(NumW);
        end
      end else if (busy) begin
        num <= num << 1;
        if (!diff[LifeW+1]) begin
          rem <= diff[LifeW:0];
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          rsp.alpha <= (quo[NumW-2:7] != '0) ? 8'd255 : {quo[6:0], !diff[LifeW+1]};
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !req.start)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("done held");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst) !busy |-> !$rose(cnt == 6'd1))
    else $error("counter moved while idle");
`endif
endmodule
`default_nettype wire

// ===== hdl/particle_fade_quad_generator.sv =====
`default_nettype none
// Particle ring of up to MAX_PARTICLES entries that expands each particle into
// four quad corners. One request is handled at a time: an add writes the ring
// and hands out one status result, a tick pops expired particles from the front
// and then does one read-modify-write per particle through the ring memory, and a
// draw runs the 32-step serial divider that computes alpha for each particle and
// then hands out its four corners. stall is low only when the sequencer is
// idle.
module particle_fade_quad_generator import pfqg_pkg::*; #(
  parameter int MAX_PARTICLES = MaxParticles
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic signed [19:0] pos_x,
  input  wire logic signed [19:0] pos_y,
  input  wire logic [23:0] elapsed_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic signed [19:0] vert_x,
  output logic signed [19:0] vert_y,
  output logic [12:0]      tex_u,
  output logic [12:0]      tex_v,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             last
);
  localparam int IdxW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CntW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_OUT, S_POP_RD, S_POP_CHK, S_SUB_RD, S_SUB_WR,
    S_DRW_RD, S_DRW_DIV, S_DRW_WAIT, S_DRW_EMIT
  } state_t;

  // Configuration registers.
  logic [23:0] fill_color, base_life;
  logic [11:0] tex_left, tex_top, tex_width, tex_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= 24'hFFFFFF;
      base_life <= 24'd1000000;
      tex_left <= '0;
      tex_top <= '0;
      tex_width <= 12'd8;
      tex_height <= 12'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgColor:  fill_color <= cfg_data;
        CfgBase:   base_life <= cfg_data;
        CfgLeft:   tex_left <= cfg_data[11:0];
        CfgTop:    tex_top <= cfg_data[11:0];
        CfgWidth:  tex_width <= cfg_data[11:0];
        CfgHeight: tex_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Ring memory, one entry of position and life per slot.
  logic [PosW-1:0]  mem_x [MAX_PARTICLES];
  logic [PosW-1:0]  mem_y [MAX_PARTICLES];
  logic [LifeW-1:0] mem_l [MAX_PARTICLES];
  logic             we_pos, we_life;
  logic [IdxW-1:0]  waddr, raddr;
  logic [PosW-1:0]  wx, wy;
  logic [LifeW-1:0] wl;
  logic [PosW-1:0]  rx, ry;
  logic [LifeW-1:0] rl;

  always_ff @(posedge clk) begin
    if (we_pos) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    if (we_life) begin
      mem_l[waddr] <= wl;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
    rl <= mem_l[raddr];
  end

  state_t          state;
  logic [IdxW-1:0] head;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [1:0]      corner;
  logic [23:0]     dt;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic [7:0]      alpha_q;

  pfqg_alpha_div u_div (.clk(clk), .rst(rst), .base(base_life), .req(dreq), .rsp(drsp));

  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] h,
                                           input logic [CntW-1:0] o);
    logic [CntW:0] s;
    s = {1'b0, CntW'(h)} + {1'b0, o};
    if (s >= (CntW+1)'(MAX_PARTICLES)) s = s - (CntW+1)'(MAX_PARTICLES);
    return s[IdxW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign raddr = slot(head, idx);
  assign wx = pos_x;
  assign wy = pos_y;
  assign we_pos = (state == S_IDLE) && in_valid && req_type == ReqAdd
                  && count < CntW'(MAX_PARTICLES);
  assign we_life = we_pos || state == S_SUB_WR;
  assign waddr = we_pos ? slot(head, count) : raddr;
  assign wl = we_pos ? base_life : ((rl > dt) ? rl - dt : '0);
  assign dreq.start = (state == S_DRW_DIV);
  assign dreq.life = rl;

  // Corner offsets from the particle position, the same for every corner.
  logic [PosW-1:0] hx, hy;
  assign hx = {5'd0, tex_width, 3'd0};
  assign hy = {5'd0, tex_height, 3'd0};

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_valid) begin
            dt <= elapsed_us;
            case (req_type)
              ReqAdd: begin
                out_valid <= 1'b1;
                {vert_x, vert_y, tex_u, tex_v, red, green, blue, alpha} <= '0;
                last <= 1'b1;
                if (count < CntW'(MAX_PARTICLES)) begin
                  status <= StAddOk;
                  count <= count + 1'b1;
                end else begin
                  status <= StAddDrop;
                end
                state <= S_OUT;
              end
              ReqTick: state <= S_POP_RD;
              ReqDraw: state <= (count == '0) ? S_IDLE : S_DRW_RD;
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_POP_RD: begin
          if (count == '0) state <= S_IDLE;
          else state <= S_POP_CHK;
        end
        S_POP_CHK: begin
          if (rl == '0) begin
            head <= slot(head, CntW'(1));
            count <= count - 1'b1;
            state <= S_POP_RD;
          end else begin
            state <= S_SUB_RD;
          end
        end
        S_SUB_RD: begin
          if (idx == count) state <= S_IDLE;
          else state <= S_SUB_WR;
        end
        S_SUB_WR: begin
          idx <= idx + 1'b1;
          state <= S_SUB_RD;
        end
        S_DRW_RD: state <= S_DRW_DIV;
        S_DRW_DIV: state <= S_DRW_WAIT;
        S_DRW_WAIT: begin
          if (drsp.done) begin
            alpha_q <= drsp.alpha;
            corner <= 2'd0;
            state <= S_DRW_EMIT;
          end
        end
        S_DRW_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= StVertex;
            vert_x <= (corner == 2'd0 || corner == 2'd3) ? rx - hx : rx + hx;
            vert_y <= (corner[1]) ? ry + hy : ry - hy;
            tex_u <= (corner == 2'd0 || corner == 2'd3) ? {1'b0, tex_left}
                     : {1'b0, tex_left} + {1'b0, tex_width};
            tex_v <= (corner[1]) ? {1'b0, tex_top} + {1'b0, tex_height}
                     : {1'b0, tex_top};
            red <= fill_color[23:16];
            green <= fill_color[15:8];
            blue <= fill_color[7:0];
            alpha <= alpha_q;
            last <= (corner == 2'd3) && (idx + 1'b1 == count);
            corner <= corner + 2'd1;
            if (corner == 2'd3) begin
              idx <= idx + 1'b1;
              state <= (idx + 1'b1 == count) ? S_OUT : S_DRW_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_IDLE && state != S_OUT && state != S_DRW_EMIT
          && out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_PARTICLES)) else $error("ring overfilled");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_add_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && req_type == ReqAdd) |=> out_valid && last)
    else $error("add result missing");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top import pfqg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code outside the defined set; the block must ignore it.
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [12:0]       u;
    logic [12:0]       v;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [7:0]        a;
    logic              last;
  } corner_t;

  // Mirror of the particle ring that forecasts the corners and add replies.
  class quad_forecast;
    logic [23:0] color = 24'hFFFFFF;
    logic [23:0] base_life = 24'd1000000;
    logic [11:0] left = 0, top = 0, width = 8, height = 8;
    logic [19:0] px[MaxParticles];
    logic [19:0] py[MaxParticles];
    logic [23:0] life[MaxParticles];
    int unsigned head = 0, count = 0;
    corner_t pending_corners[$];
    int errors = 0, checked = 0, drops = 0, sat_alpha = 0;

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        CfgColor:  color = val;
        CfgBase:   base_life = val;
        CfgLeft:   left = val[11:0];
        CfgTop:    top = val[11:0];
        CfgWidth:  width = val[11:0];
        CfgHeight: height = val[11:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] fade(logic [23:0] l);
      longint unsigned q;
      if (base_life == 0) return (l != 0) ? 8'd255 : 8'd0;
      q = (64'd255 * l) / base_life;
      if (q > 255) begin
        sat_alpha++;
        return 8'd255;
      end
      return q[7:0];
    endfunction

    function void note_request(logic [1:0] req, logic [19:0] x, logic [19:0] y,
                               logic [23:0] dt);
      corner_t c;
      int unsigned s;
      logic [19:0] hx, hy;
      logic [7:0] al;
      c = '0;
      case (req)
        ReqAdd: begin
          if (count >= MaxParticles) begin
            c.status = StAddDrop;
            drops++;
          end else begin
            s = (head + count) % MaxParticles;
            px[s] = x;
            py[s] = y;
            life[s] = base_life;
            count++;
            c.status = StAddOk;
          end
          c.last = 1'b1;
          pending_corners.insert(pending_corners.size(), c);
        end
        ReqTick: begin
          // Pop expired particles from the front, then age the rest.
          while (count > 0 && life[head] == 0) begin
            head = (head + 1) % MaxParticles;
            count--;
          end
          for (int i = 0; i < count; i++) begin
            s = (head + i) % MaxParticles;
            life[s] = (life[s] > dt) ? life[s] - dt : 24'd0;
          end
        end
        ReqDraw: begin
          hx = {5'd0, width, 3'd0};
          hy = {5'd0, height, 3'd0};
          for (int i = 0; i < count; i++) begin
            s = (head + i) % MaxParticles;
            al = fade(life[s]);
            for (int k = 0; k < 4; k++) begin
              c = '0;
              c.status = StVertex;
              c.vx = (k == 0 || k == 3) ? px[s] - hx : px[s] + hx;
              c.vy = (k < 2) ? py[s] - hy : py[s] + hy;
              c.u = (k == 0 || k == 3) ? {1'b0, left} : left + width;
              c.v = (k < 2) ? {1'b0, top} : top + height;
              c.r = color[23:16];
              c.g = color[15:8];
              c.b = color[7:0];
              c.a = al;
              c.last = (i == count - 1) && (k == 3);
              pending_corners.insert(pending_corners.size(), c);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH at %0t result %0d: %s got %0h expected %0h",
               $time, checked, what, got, want);
    endtask

    task check_corner(corner_t got);
      corner_t w;
      if (pending_corners.size() == 0) begin
        report("unexpected result, status", got.status, 0);
        return;
      end
      w = pending_corners[0];
      pending_corners.delete(0);
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.vx !== w.vx) report("vert_x", got.vx, w.vx);
      if (got.vy !== w.vy) report("vert_y", got.vy, w.vy);
      if (got.u !== w.u) report("tex_u", got.u, w.u);
      if (got.v !== w.v) report("tex_v", got.v, w.v);
      if (got.r !== w.r) report("red", got.r, w.r);
      if (got.g !== w.g) report("green", got.g, w.g);
      if (got.b !== w.b) report("blue", got.b, w.b);
      if (got.a !== w.a) report("alpha", got.a, w.a);
      if (got.last !== w.last) report("last", got.last, w.last);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic signed [19:0] pos_x = '0;
  logic signed [19:0] pos_y = '0;
  logic [23:0] elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [19:0] vert_x, vert_y;
  logic [12:0] tex_u, tex_v;
  logic [7:0] red, green, blue, alpha;
  logic last;

  quad_forecast sb = new();
  int burst_left = 0;
  int sent = 0;
  bit valid_high = 0;
  bit long_hold_req = 0;

  particle_fade_quad_generator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one request and wait until it is taken; gaps fall between bursts.
  task automatic send(logic [1:0] req, logic [19:0] x, logic [19:0] y,
                      logic [23:0] dt);
    in_valid <= 1'b1;
    req_type <= req;
    pos_x <= x;
    pos_y <= y;
    elapsed_us <= dt;
    valid_high = 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, x, y, dt);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      valid_high = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 12);
    end
  endtask

  // Lower valid, wait for all results and for a trailing tick to finish.
  task automatic settle();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 0;
    end
    while (sb.pending_corners.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_regs(logic [23:0] c, logic [23:0] b, logic [11:0] l,
                          logic [11:0] t, logic [11:0] w, logic [11:0] h);
    logic [23:0] vals[6];
    vals = '{c, b, {12'd0, l}, {12'd0, t}, {12'd0, w}, {12'd0, h}};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      sb.set_reg(3'(i), vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly adds and modest ticks so the ring stays populated, some noise.
  task automatic random_phase(int n);
    int pick;
    logic [23:0] dt;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1:    dt = 24'($urandom);
        2:       dt = '0;
        default: dt = 24'($urandom_range(0, sb.base_life / 3 + 1));
      endcase
      if (pick < 45) send(ReqAdd, 20'($urandom), 20'($urandom), 24'($urandom));
      else if (pick < 70) send(ReqTick, 20'($urandom), 20'($urandom), dt);
      else if (pick < 97) send(ReqDraw, 20'($urandom), 20'($urandom), 24'($urandom));
      else send(ReqUnused, 20'($urandom), 20'($urandom), 24'($urandom));
    end
  endtask

  // Receiver stalls in segments of differing density, plus one long hold.
  initial begin
    int seg_left, mode, hold_cnt;
    seg_left = 0;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_cnt = 400;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest forecast.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_corner('{status, vert_x, vert_y, tex_u, tex_v, red, green, blue,
                        alpha, last});
  end

  initial begin
    #3ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = 1000;

    // Directed: empty draw, extreme positions, aging, fill and overflow.
    send(ReqDraw, 0, 0, 0);
    send(ReqAdd, 20'h80000, 20'h7FFFF, 24'hFFFFFF);
    send(ReqAdd, 20'h7FFFF, 20'h80000, 0);
    send(ReqAdd, 20'h00000, 20'hFFFFF, 0);
    send(ReqDraw, 0, 0, 0);
    send(ReqTick, 0, 0, 0);
    send(ReqTick, 0, 0, 24'd300000);
    send(ReqDraw, 0, 0, 0);
    long_hold_req = 1;
    for (int i = 0; i < 14; i++) send(ReqAdd, 20'($urandom), 20'($urandom), 0);
    send(ReqDraw, 0, 0, 0);
    send(ReqTick, 0, 0, 24'hFFFFFF);
    send(ReqDraw, 0, 0, 0);
    send(ReqTick, 0, 0, 24'd1);
    send(ReqDraw, 0, 0, 0);
    send(ReqUnused, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
    settle();

    // Smallest nonzero lifetime and the largest texture rectangle.
    set_regs(24'h000000, 24'd1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    random_phase(60);
    settle();
    // Longest lifetime, zero-size rectangle.
    set_regs(24'($urandom), 24'hFFFFFF, 12'd0, 12'd0, 12'd0, 12'd0);
    for (int i = 0; i < 6; i++) send(ReqAdd, 20'($urandom), 20'($urandom), 0);
    random_phase(55);
    settle();
    // Lowering the lifetime leaves older particles above it: alpha saturates.
    set_regs(24'($urandom), 24'd1000, 12'($urandom), 12'($urandom),
             12'($urandom_range(0, 64)), 12'($urandom_range(0, 64)));
    send(ReqDraw, 0, 0, 0);
    random_phase(60);
    settle();
    set_regs(24'hFFFFFF, 24'd1000000, 12'($urandom), 12'($urandom),
             12'($urandom), 12'($urandom));
    random_phase(60);
    settle();

    $display("Covered %0d requests and %0d results (%0d adds dropped full,",
             sent, sb.checked, sb.drops);
    $display("  %0d saturated fades) across five register settings.", sb.sat_alpha);
    if (sb.errors == 0 && sb.pending_corners.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/pfqg_pkg.sv
hdl/pfqg_alpha_div.sv
hdl/particle_fade_quad_generator.sv
bench/tb_top.sv
